@@ rtl/q4gm_pkg.sv @@
// Shared constants, types and codes of the 4-bit group-quantised row dot product.
package q4gm_pkg;

  // Plane sums saturate to a 17-bit signed range.
  localparam int SUM_W   = 17;
  localparam int SUM_MAX = 65535;
  localparam int SUM_MIN = -65536;

  // Packed weight nibbles carry an offset.
  localparam int W_OFFSET = 8;

  // High plane weighs 128 against the low plane.
  localparam int PLANE_SHIFT = 7;

  // Combined group dot product: 128 * high + low.
  localparam int DOT_W = SUM_W + PLANE_SHIFT + 1;

  // Unpacked float datapath: significand word and exponent width.
  localparam int M_W = 50;
  localparam int E_W = 11;

  localparam logic [31:0] NAN_BITS = 32'h7FC0_0000;

  // Operations of the shared float unit.
  typedef enum logic [1:0] {
    FOP_CVT  = 2'd0,  // signed integer in a[DOT_W-1:0] to single
    FOP_MULH = 2'd1,  // half in a[15:0] times single b
    FOP_MUL  = 2'd2,  // single times single
    FOP_ADD  = 2'd3   // single plus single
  } fpu_op_t;

  typedef struct packed {
    logic        start;
    fpu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] bits;
  } fpu_rsp_t;

endpackage

@@ rtl/q4gm_in_if.sv @@
// Input channel: one packed weight byte with its activation planes and scales.
interface q4gm_in_if;
  logic              valid;
  logic              ready;
  logic [7:0]        weight_pair;
  logic signed [7:0] even_high_plane;
  logic signed [7:0] even_low_plane;
  logic signed [7:0] odd_high_plane;
  logic signed [7:0] odd_low_plane;
  logic [15:0]       weight_scale_half;
  logic [31:0]       act_scale_bits;
  logic              group_end;
  logic              row_end;

  modport source (
    output valid, weight_pair, even_high_plane, even_low_plane, odd_high_plane,
    output odd_low_plane, weight_scale_half, act_scale_bits, group_end, row_end,
    input  ready
  );

  modport sink (
    input  valid, weight_pair, even_high_plane, even_low_plane, odd_high_plane,
    input  odd_low_plane, weight_scale_half, act_scale_bits, group_end, row_end,
    output ready
  );
endinterface

@@ rtl/q4gm_out_if.sv @@
// Output channel: one single-precision row total.
interface q4gm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_value_bits;

  modport source (output valid, row_value_bits, input ready);
  modport sink   (input valid, row_value_bits, output ready);
endinterface

@@ rtl/q4_group_matvec_row.sv @@
// Top level: 4-bit group-quantised row dot product with a shared float unit.
//
// Channels: item (sink) takes one packed weight byte per transfer, with the
// even and odd activation planes, the group's half weight scale and single
// activation scale, and the group_end / row_end marks. result (source) gives
// one single-precision row total per row, on the byte that carries row_end.
// A byte that closes nothing leaves item.ready high, so plain bytes stream
// at one per cycle while no group close is running.
// A byte that closes a group (group_end or row_end) starts four passes
// through the one float unit: scale product, integer-to-float of the group
// sum, scaled product, row accumulate. Each pass lasts as long as the
// unit's normalising shifter needs, so item.ready stays low after a group
// close until the accumulate ends; after a row close, past the emit step.
// The row total waits in an output register; a stalled receiver holds only
// the next row close, and plain bytes keep flowing behind it.
// Reset clears the plane sums, the row accumulator (to +0.0) and all valid
// state; the block is ready in the first cycle after reset.
module q4_group_matvec_row import q4gm_pkg::*; (
  input logic   clk,
  input logic   rst,
  q4gm_in_if.sink   item,
  q4gm_out_if.source result
);

  typedef enum logic [2:0] {S_IDLE, S_SCALE, S_CVT, S_PROD, S_ACC, S_EMIT} state_t;

  state_t                  state;
  logic                    go;
  logic signed [SUM_W-1:0] high_sum, low_sum;
  logic signed [DOT_W-1:0] dot;
  logic [15:0]             ws;
  logic [31:0]             xs;
  logic                    row_pend;
  logic [31:0]             t_scale, t_dot, acc;
  logic                    out_valid;
  logic [31:0]             out_bits;
  fpu_req_t                req;
  fpu_rsp_t                rsp;

  // Byte products and saturating plane sums
  logic signed [4:0]       we, wo;
  logic signed [12:0]      peh, pel, poh, pol;
  logic signed [SUM_W:0]   h_raw, l_raw;
  logic signed [SUM_W-1:0] h_next, l_next;
  logic                    accept, close;

  always_comb begin
    we     = $signed({1'b0, item.weight_pair[3:0]}) - 5'(W_OFFSET);
    wo     = $signed({1'b0, item.weight_pair[7:4]}) - 5'(W_OFFSET);
    peh    = 13'(we) * 13'(item.even_high_plane);
    pel    = 13'(we) * 13'(item.even_low_plane);
    poh    = 13'(wo) * 13'(item.odd_high_plane);
    pol    = 13'(wo) * 13'(item.odd_low_plane);
    h_raw  = (SUM_W+1)'(high_sum) + (SUM_W+1)'(peh) + (SUM_W+1)'(poh);
    l_raw  = (SUM_W+1)'(low_sum) + (SUM_W+1)'(pel) + (SUM_W+1)'(pol);
    h_next = (h_raw > (SUM_W+1)'(SUM_MAX)) ? SUM_W'(SUM_MAX)
           : (h_raw < (SUM_W+1)'(SUM_MIN)) ? SUM_W'(SUM_MIN) : h_raw[SUM_W-1:0];
    l_next = (l_raw > (SUM_W+1)'(SUM_MAX)) ? SUM_W'(SUM_MAX)
           : (l_raw < (SUM_W+1)'(SUM_MIN)) ? SUM_W'(SUM_MIN) : l_raw[SUM_W-1:0];
  end

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign close      = item.group_end || item.row_end;

  // Route the operands of the current pass to the float unit
  always_comb begin
    req.start = go;
    req.op    = FOP_CVT;
    req.a     = '0;
    req.b     = '0;
    case (state)
      S_SCALE: begin
        req.op = FOP_MULH;
        req.a  = {16'b0, ws};
        req.b  = xs;
      end
      S_CVT: begin
        req.op = FOP_CVT;
        req.a  = 32'(dot);
      end
      S_PROD: begin
        req.op = FOP_MUL;
        req.a  = t_scale;
        req.b  = t_dot;
      end
      S_ACC: begin
        req.op = FOP_ADD;
        req.a  = acc;
        req.b  = t_scale;
      end
      default: begin
        req.op = FOP_CVT;
      end
    endcase
  end

  q4gm_fpu u_fpu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Sequencer, sums, accumulator and output register
  always_ff @(posedge clk) begin
    // pulse the float unit start on entry to each pass
    go <= !rst && ((state == S_IDLE && accept && close) ||
                   (rsp.done && (state == S_SCALE || state == S_CVT || state == S_PROD)));
    if (rst) begin
      state     <= S_IDLE;
      high_sum  <= '0;
      low_sum   <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (close) begin
              // hold the group total and start the scale pass
              high_sum <= '0;
              low_sum  <= '0;
              dot      <= (DOT_W'(h_next) <<< PLANE_SHIFT) + DOT_W'(l_next);
              ws       <= item.weight_scale_half;
              xs       <= item.act_scale_bits;
              row_pend <= item.row_end;
              state    <= S_SCALE;
            end else begin
              high_sum <= h_next;
              low_sum  <= l_next;
            end
          end
        end
        S_SCALE: begin
          if (rsp.done) begin
            t_scale <= rsp.bits;
            state   <= S_CVT;
          end
        end
        S_CVT: begin
          if (rsp.done) begin
            t_dot <= rsp.bits;
            state <= S_PROD;
          end
        end
        S_PROD: begin
          if (rsp.done) begin
            t_scale <= rsp.bits;
            state   <= S_ACC;
          end
        end
        S_ACC: begin
          if (rsp.done) begin
            acc   <= rsp.bits;
            state <= row_pend ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid <= 1'b1;
            out_bits  <= (acc[30:23] == 8'hFF && acc[22:0] != '0) ? NAN_BITS : acc;
            acc       <= '0;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.valid          = out_valid;
  assign result.row_value_bits = out_bits;

  a_sums_clear: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> (high_sum == '0 && low_sum == '0))
    else $error("plane sums not cleared while a group close runs");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && (!out_valid || result.ready)) |=> acc == '0)
    else $error("row accumulator not cleared after a row transfer");

  a_valid_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EMIT))
    else $error("row result raised outside the emit step");

endmodule

@@ rtl/q4gm_fpu.sv @@
// Shared iterative float unit: convert, multiply and add with round-to-nearest-even.
module q4gm_fpu import q4gm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  fpu_req_t req,
  output fpu_rsp_t rsp
);

  typedef struct packed {
    logic                  s;
    logic                  nan;
    logic                  inf;
    logic signed [E_W-1:0] e;
    logic [23:0]           sig;
  } fop_t;

  typedef enum logic [1:0] {F_IDLE, F_NORM, F_PACK} fstate_t;

  function automatic fop_t unpack_sp(input logic [31:0] x);
    fop_t u;
    u.s   = x[31];
    u.nan = (x[30:23] == 8'hFF) && (x[22:0] != '0);
    u.inf = (x[30:23] == 8'hFF) && (x[22:0] == '0);
    u.sig = {x[30:23] != '0, x[22:0]};
    u.e   = (x[30:23] == '0) ? E_W'(-126)
                             : $signed({3'b000, x[30:23]}) - E_W'(127);
    return u;
  endfunction

  function automatic fop_t unpack_hp(input logic [15:0] h);
    fop_t u;
    u.s   = h[15];
    u.nan = (h[14:10] == 5'h1F) && (h[9:0] != '0);
    u.inf = (h[14:10] == 5'h1F) && (h[9:0] == '0);
    u.sig = {h[14:10] != '0, h[9:0], 13'b0};
    u.e   = (h[14:10] == '0) ? E_W'(-14)
                             : $signed({6'b000000, h[14:10]}) - E_W'(15);
    return u;
  endfunction

  fstate_t               state;
  logic [M_W-1:0]        m;
  logic signed [E_W-1:0] e;
  logic                  s;
  logic                  spec;
  logic [31:0]           spec_bits;
  logic [31:0]           res;
  logic                  done;

  // Operand set-up signals
  fop_t                  ua, ub, uh, ma, big, sml;
  logic [47:0]           prod;
  logic                  a_ge;
  logic signed [E_W-1:0] dexp;
  logic [5:0]            ash;
  logic [M_W-1:0]        full_s, sm, mb;
  logic                  cv_neg;
  logic [DOT_W-1:0]      cv_mag;
  logic                  nan_c;
  logic [M_W-1:0]        a_m;
  logic signed [E_W-1:0] a_e;
  logic                  a_s;
  logic                  a_spec;
  logic [31:0]           a_spec_bits;

  // Form the raw significand, exponent and sign of the requested operation
  always_comb begin
    ua     = unpack_sp(req.a);
    ub     = unpack_sp(req.b);
    uh     = unpack_hp(req.a[15:0]);
    ma     = (req.op == FOP_MULH) ? uh : ua;
    prod   = ma.sig * ub.sig;
    a_ge   = req.a[30:0] >= req.b[30:0];
    big    = a_ge ? ua : ub;
    sml    = a_ge ? ub : ua;
    dexp   = big.e - sml.e;
    full_s = {1'b0, sml.sig, 25'b0};
    mb     = {1'b0, big.sig, 25'b0};
    ash    = dexp[5:0];
    if (dexp > E_W'(M_W - 1)) begin
      sm = M_W'(sml.sig != '0);
    end else begin
      sm = (full_s >> ash) | M_W'(|(full_s & ~({M_W{1'b1}} << ash)));
    end
    cv_neg      = req.a[DOT_W-1];
    cv_mag      = cv_neg ? (~req.a[DOT_W-1:0] + DOT_W'(1)) : req.a[DOT_W-1:0];
    nan_c       = 1'b0;
    a_m         = '0;
    a_e         = '0;
    a_s         = 1'b0;
    a_spec      = 1'b0;
    a_spec_bits = NAN_BITS;
    case (req.op)
      FOP_CVT: begin
        a_m = M_W'(cv_mag);
        a_e = '0;
        a_s = cv_neg;
      end
      FOP_MULH, FOP_MUL: begin
        a_m    = M_W'(prod);
        a_e    = ma.e + ub.e - E_W'(46);
        a_s    = ma.s ^ ub.s;
        nan_c  = ma.nan || ub.nan || (ma.inf && ub.sig == '0) || (ub.inf && ma.sig == '0);
        a_spec = nan_c || ma.inf || ub.inf;
        a_spec_bits = nan_c ? NAN_BITS : {a_s, 8'hFF, 23'b0};
      end
      FOP_ADD: begin
        a_m    = (big.s == sml.s) ? (mb + sm) : (mb - sm);
        a_e    = big.e - E_W'(48);
        a_s    = (a_m == '0) ? (ua.s & ub.s) : big.s;
        nan_c  = ua.nan || ub.nan || (ua.inf && ub.inf && ua.s != ub.s);
        a_spec = nan_c || ua.inf || ub.inf;
        a_spec_bits = nan_c ? NAN_BITS : {ua.inf ? ua.s : ub.s, 8'hFF, 23'b0};
      end
      default: begin
        a_m = '0;
      end
    endcase
  end

  // Round and pack signals
  logic signed [11:0] ef, neg;
  logic               den;
  logic [5:0]         sh;
  logic [11:0]        ef_eff;
  logic [M_W-1:0]     sv;
  logic [23:0]        q;
  logic               inc;
  logic [24:0]        r;
  logic [34:0]        psum;
  logic [31:0]        pack_bits;

  // Round to nearest even, with gradual underflow and overflow to infinity
  always_comb begin
    ef     = 12'($signed(e)) + 12'sd176;
    den    = ef < 12'sd1;
    neg    = 12'sd1 - ef;
    sh     = '0;
    if (den) begin
      sh = (neg > 12'sd50) ? 6'd50 : neg[5:0];
    end
    ef_eff = den ? 12'd1 : ef;
    sv     = (m >> sh) | M_W'(|(m & ~({M_W{1'b1}} << sh)));
    q      = sv[M_W-1 -: 24];
    inc    = sv[25] & ((|sv[24:0]) | q[0]);
    r      = {1'b0, q} + 25'(inc);
    psum   = {ef_eff - 12'd1, 23'b0} + 35'(r);
    if (m == '0) begin
      pack_bits = {s, 31'b0};
    end else if (psum >= 35'h07F80_0000) begin
      pack_bits = {s, 8'hFF, 23'b0};
    end else begin
      pack_bits = {s, psum[30:0]};
    end
  end

  // Sequence: set up, normalise by 16, 4 or 1 bits a cycle, round and pack
  always_ff @(posedge clk) begin
    done <= !rst && (state == F_PACK);
    if (rst) begin
      state <= F_IDLE;
    end else begin
      case (state)
        F_IDLE: begin
          if (req.start) begin
            m         <= a_m;
            e         <= a_e;
            s         <= a_s;
            spec      <= a_spec;
            spec_bits <= a_spec_bits;
            state     <= a_spec ? F_PACK : F_NORM;
          end
        end
        F_NORM: begin
          if (m == '0 || m[M_W-1]) begin
            state <= F_PACK;
          end else if (m[M_W-1 -: 16] == '0) begin
            m <= m << 16;
            e <= e - E_W'(16);
          end else if (m[M_W-1 -: 4] == '0) begin
            m <= m << 4;
            e <= e - E_W'(4);
          end else begin
            m <= m << 1;
            e <= e - E_W'(1);
          end
        end
        F_PACK: begin
          res   <= spec ? spec_bits : pack_bits;
          state <= F_IDLE;
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.bits = res;

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == F_IDLE) else $error("float unit started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("float unit done held for more than one cycle");

  a_pack_norm: assert property (@(posedge clk) disable iff (rst)
    (state == F_PACK && !spec) |-> (m == '0 || m[M_W-1]))
    else $error("packing an unnormalised significand");

endmodule
